@@ design/hcvl_pkg.sv @@
// Shared types, codes and position-mapping functions for the Hamming codec.
package hcvl_pkg;

  localparam int MAX_CODE_BITS = 64;
  localparam int DATA_W        = 57;
  localparam int CODE_W        = 64;
  localparam int SYN_W         = 7;
  localparam int NBITS_W       = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_ODD = 1'b1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_CORRECTED     = 2'd1,
    ST_UNCORRECTABLE = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]       p;
    logic [SYN_W-1:0] len;
  } len_cfg_t;

  // least p with n + p + 1 <= 2^p
  function automatic logic [2:0] parity_count(logic [SYN_W-1:0] n);
    logic [2:0] p;
    p = 3'd1;
    for (int i = 0; i < 7; i++) begin
      if (8'({1'b0, n}) + 8'(p) + 8'd1 > (8'd1 << p)) begin
        p = p + 3'd1;
      end
    end
    return p;
  endfunction

  function automatic len_cfg_t derive_len(logic [NBITS_W-1:0] v);
    logic [SYN_W-1:0] n;
    logic [2:0]       p;
    len_cfg_t         r;
    n = (v == '0) ? SYN_W'(1) : SYN_W'(v);
    p = parity_count(n);
    // shrink the data length until the codeword fits
    for (int i = 0; i < 8; i++) begin
      if (n > SYN_W'(1) && 8'(n) + 8'(p) > 8'(MAX_CODE_BITS)) begin
        n = n - SYN_W'(1);
        p = parity_count(n);
      end
    end
    r.p   = p;
    r.len = n + SYN_W'(p);
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] len_mask(logic [SYN_W-1:0] len);
    logic [CODE_W-1:0] m;
    for (int j = 1; j <= CODE_W; j++) begin
      m[j-1] = (SYN_W'(j) <= len);
    end
    return m;
  endfunction

  function automatic logic [SYN_W-1:0] parity_mask(logic [2:0] p);
    logic [SYN_W-1:0] m;
    for (int k = 0; k < SYN_W; k++) begin
      m[k] = (3'(k) < p);
    end
    return m;
  endfunction

  function automatic logic is_pow2(int j);
    return (j != 0) && ((j & (j - 1)) == 0);
  endfunction

  // place data bits D1.. at the non-power-of-two positions
  function automatic logic [CODE_W-1:0] scatter(logic [DATA_W-1:0] d);
    logic [CODE_W-1:0] cw;
    int                idx;
    cw  = '0;
    idx = 0;
    for (int j = 1; j <= CODE_W; j++) begin
      if (!is_pow2(j)) begin
        cw[j-1] = d[idx];
        idx++;
      end
    end
    return cw;
  endfunction

  function automatic logic [DATA_W-1:0] gather(logic [CODE_W-1:0] cw);
    logic [DATA_W-1:0] d;
    int                idx;
    d   = '0;
    idx = 0;
    for (int j = 1; j <= CODE_W; j++) begin
      if (!is_pow2(j)) begin
        d[idx] = cw[j-1];
        idx++;
      end
    end
    return d;
  endfunction

  // XOR of the positions of all set bits
  function automatic logic [SYN_W-1:0] position_xor(logic [CODE_W-1:0] cw);
    logic [SYN_W-1:0] s;
    s = '0;
    for (int j = 1; j <= CODE_W; j++) begin
      for (int k = 0; k < SYN_W; k++) begin
        if (((j >> k) & 1) == 1) begin
          s[k] = s[k] ^ cw[j-1];
        end
      end
    end
    return s;
  endfunction

endpackage

@@ design/hcvl_in_if.sv @@
// Request channel of the Hamming codec: valid/ready with mode, data and codeword.
interface hcvl_in_if
  import hcvl_pkg::*;
();

  logic              valid;
  logic              ready;
  logic              mode;
  logic [DATA_W-1:0] data_in;
  logic [CODE_W-1:0] code_in;

  modport source (output valid, output mode, output data_in, output code_in, input ready);
  modport sink   (input valid, input mode, input data_in, input code_in, output ready);
endinterface

@@ design/hcvl_out_if.sv @@
// Result channel of the Hamming codec: valid/ready with codeword, data, syndrome, status.
interface hcvl_out_if
  import hcvl_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] codeword;
  logic [DATA_W-1:0] data_out;
  logic [SYN_W-1:0]  syndrome;
  logic [1:0]        status;

  modport source (output valid, output codeword, output data_out, output syndrome,
                  output status, input ready);
  modport sink   (input valid, input codeword, input data_out, input syndrome,
                  input status, output ready);
endinterface

@@ design/hamming_codec_variable_length.sv @@
// Hamming single-error-correcting codec with configurable data length and parity sense.
// Each request is captured in an input register, encoded or checked/corrected by XOR
// trees in the next cycle, and held in a result register until taken. One request is
// accepted per cycle while the result side does not stall. A stall on the result side
// holds both stages. data_bits and parity_odd are written through the cfg port; the
// user must write them only while no request is in flight (the block does not enforce
// this). The parity count, codeword length and masks are derived at write time
// (data_bits 0 acts as 1, above 57 acts as 57).
module hamming_codec_variable_length
  import hcvl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hcvl_in_if.sink               in_ch,
  hcvl_out_if.source            out_ch
);

  localparam len_cfg_t RST_LEN = derive_len(NBITS_W'(4));

  // derived configuration
  logic              parity_odd_r;
  logic [SYN_W-1:0]  len_r;
  logic [SYN_W-1:0]  pmask_r;
  logic [CODE_W-1:0] lmask_r;
  len_cfg_t          cfg_len;

  assign cfg_len = derive_len(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_odd_r <= 1'b0;
      len_r        <= RST_LEN.len;
      pmask_r      <= parity_mask(RST_LEN.p);
      lmask_r      <= len_mask(RST_LEN.len);
    end else if (cfg_we) begin
      if (cfg_index == REG_DATA_BITS) begin
        len_r   <= cfg_len.len;
        pmask_r <= parity_mask(cfg_len.p);
        lmask_r <= len_mask(cfg_len.len);
      end else begin
        parity_odd_r <= cfg_wdata[0];
      end
    end
  end

  // pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic adv1;
  logic adv2;

  assign adv2        = !out_valid_r || out_ch.ready;
  assign adv1        = !s1_valid_r || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // input register
  logic              s1_mode_r;
  logic [DATA_W-1:0] s1_data_r;
  logic [CODE_W-1:0] s1_code_r;

  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      s1_mode_r <= in_ch.mode;
      s1_data_r <= in_ch.data_in;
      s1_code_r <= in_ch.code_in;
    end
  end

  // encode / check-and-correct
  logic [SYN_W-1:0]  flip;
  logic [CODE_W-1:0] enc_cw;
  logic [SYN_W-1:0]  enc_par;
  logic [CODE_W-1:0] dec_in;
  logic [SYN_W-1:0]  dec_syn;
  logic [CODE_W-1:0] dec_cw;
  status_t           dec_status;
  logic [CODE_W-1:0] res_cw;
  logic [SYN_W-1:0]  res_syn;
  status_t           res_status;

  assign flip = parity_odd_r ? pmask_r : '0;

  always_comb begin
    enc_cw  = scatter(s1_data_r) & lmask_r;
    enc_par = (position_xor(enc_cw) ^ flip) & pmask_r;
    for (int k = 0; k < SYN_W; k++) begin
      enc_cw[(1 << k) - 1] = enc_cw[(1 << k) - 1] | enc_par[k];
    end
  end

  always_comb begin
    dec_in  = s1_code_r & lmask_r;
    dec_syn = (position_xor(dec_in) ^ flip) & pmask_r;
    dec_cw  = dec_in;
    if (dec_syn == '0) begin
      dec_status = ST_OK;
    end else if (dec_syn > len_r) begin
      dec_status = ST_UNCORRECTABLE;
    end else begin
      dec_status = ST_CORRECTED;
      for (int j = 1; j <= CODE_W; j++) begin
        if (dec_syn == SYN_W'(j)) begin
          dec_cw[j-1] = ~dec_in[j-1];
        end
      end
    end
  end

  always_comb begin
    if (s1_mode_r == MODE_DECODE) begin
      res_cw     = dec_cw;
      res_syn    = dec_syn;
      res_status = dec_status;
    end else begin
      res_cw     = enc_cw;
      res_syn    = '0;
      res_status = ST_OK;
    end
  end

  // result register
  logic [CODE_W-1:0] out_cw_r;
  logic [DATA_W-1:0] out_data_r;
  logic [SYN_W-1:0]  out_syn_r;
  status_t           out_status_r;

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      out_cw_r     <= res_cw;
      out_data_r   <= gather(res_cw);
      out_syn_r    <= res_syn;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.codeword = out_cw_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.syndrome = out_syn_r;
  assign out_ch.status   = out_status_r;

endmodule
